// File: rtl/md5_pkg.sv
// Shared types, step constants and step tables for the MD5 compression pipeline.
package md5_pkg;

  localparam int unsigned NUM_STEPS = 64;
  localparam int unsigned NUM_WORDS = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned IN_W      = 640;
  localparam int unsigned OUT_W     = 128;

  typedef logic [WORD_W-1:0] word_t;

  // Contents of one cell of the round chain: the working words, the message
  // block and the incoming chaining value, which rides along for the final add.
  typedef struct packed {
    logic                       valid;
    word_t [NUM_WORDS-1:0]      msg;
    word_t                      ha;
    word_t                      hb;
    word_t                      hc;
    word_t                      hd;
    word_t                      a;
    word_t                      b;
    word_t                      c;
    word_t                      d;
  } cell_data_t;

  // Additive constant of each step.
  localparam word_t STEP_K [NUM_STEPS] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Left rotate amount of a step.
  function automatic int unsigned rot_amount(int unsigned step);
    int unsigned r;
    r = 7;
    case ((step / 16) * 4 + (step % 4))
      0:  r = 7;
      1:  r = 12;
      2:  r = 17;
      3:  r = 22;
      4:  r = 5;
      5:  r = 9;
      6:  r = 14;
      7:  r = 20;
      8:  r = 4;
      9:  r = 11;
      10: r = 16;
      11: r = 23;
      12: r = 6;
      13: r = 10;
      14: r = 15;
      15: r = 21;
      default: r = 7;
    endcase
    return r;
  endfunction

  // Message word taken by a step.
  function automatic int unsigned msg_index(int unsigned step);
    int unsigned idx;
    idx = 0;
    case (step / 16)
      0:       idx = step % 16;
      1:       idx = (5 * step + 1) % 16;
      2:       idx = (3 * step + 5) % 16;
      default: idx = (7 * step) % 16;
    endcase
    return idx;
  endfunction

endpackage

// File: rtl/md5_cell.sv
// One MD5 step as a pipeline cell: computes the step and hands its words on.
module md5_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                run,
  input  md5_pkg::cell_data_t din,
  output md5_pkg::cell_data_t dout
);

  localparam int unsigned GROUP = STEP / 16;
  localparam int unsigned IDX   = md5_pkg::msg_index(STEP);
  localparam int unsigned ROT   = md5_pkg::rot_amount(STEP);
  localparam md5_pkg::word_t K  = md5_pkg::STEP_K[STEP];

  md5_pkg::word_t f;
  md5_pkg::word_t sum;
  md5_pkg::word_t rotated;
  md5_pkg::word_t nb;

  // Boolean function of this step's group.
  always_comb begin
    case (GROUP)
      0:       f = (din.b & din.c) | (~din.b & din.d);
      1:       f = (din.b & din.d) | (din.c & ~din.d);
      2:       f = din.b ^ din.c ^ din.d;
      default: f = din.c ^ (din.b | ~din.d);
    endcase
  end

  // Step sum, rotate and new B word.
  assign sum     = din.a + f + K + din.msg[IDX];
  assign rotated = (sum << ROT) | (sum >> (md5_pkg::WORD_W - ROT));
  assign nb      = din.b + rotated;

  // Valid bit and payload move one cell on whenever the chain runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (run) begin
      dout.valid <= din.valid;
    end
    if (run) begin
      dout.msg <= din.msg;
      dout.ha  <= din.ha;
      dout.hb  <= din.hb;
      dout.hc  <= din.hc;
      dout.hd  <= din.hd;
      dout.a   <= din.d;
      dout.b   <= nb;
      dout.c   <= din.b;
      dout.d   <= din.c;
    end
  end

endmodule

// File: rtl/md5_out_skid.sv
// Final chaining add and output register with a skid stage.
module md5_out_skid (
  input  logic                              clk,
  input  logic                              rst,
  input  md5_pkg::cell_data_t               din,
  output logic                              run,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [md5_pkg::OUT_W-1:0]         m_tdata
);

  logic [md5_pkg::OUT_W-1:0] sum_data;
  logic [md5_pkg::OUT_W-1:0] skid_data;
  logic                      skid_valid;

  // Chaining value plus working words, word A in the lowest bits.
  assign sum_data = {din.hd + din.d, din.hc + din.c, din.hb + din.b, din.ha + din.a};

  // The round chain runs while the skid stage is empty.
  assign run = !skid_valid;

  // Control: output register valid and skid valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= din.valid;
      end
    end else if (din.valid && run) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      m_tdata <= skid_valid ? skid_data : sum_data;
    end else if (run) begin
      skid_data <= sum_data;
    end
  end

endmodule

// File: rtl/md5_block_compress.sv
// Top level of the pipelined MD5 block compression.
//
// One 512-bit block and a 128-bit chaining value enter per transfer on the
// slave side; the updated chaining value leaves on the master side. The block
// is a chain of 64 cells, one per MD5 step, followed by the final add into an
// output register with a skid stage, so a new block is taken every cycle while
// the master side does not stall. s_tready is registered and drops only once
// the output register and the skid stage both hold a result; the whole chain
// then holds.
module md5_block_compress (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // words_0_1, words_2_3, words_4_5, words_6_7, words_8_9, words_10_11,
  // words_12_13, words_14_15, chain_in_a, chain_in_b, chain_in_c, chain_in_d
  input  logic [md5_pkg::IN_W-1:0]     s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // chain_out_a, chain_out_b, chain_out_c, chain_out_d
  output logic [md5_pkg::OUT_W-1:0]    m_tdata
);

  md5_pkg::cell_data_t chain [md5_pkg::NUM_STEPS+1];
  logic                run;

  // Cell zero input: unpack the transfer.
  always_comb begin
    chain[0].valid = s_tvalid;
    for (int i = 0; i < md5_pkg::NUM_WORDS; i++) begin
      chain[0].msg[i] = s_tdata[i*md5_pkg::WORD_W +: md5_pkg::WORD_W];
    end
    chain[0].ha = s_tdata[512 +: md5_pkg::WORD_W];
    chain[0].hb = s_tdata[544 +: md5_pkg::WORD_W];
    chain[0].hc = s_tdata[576 +: md5_pkg::WORD_W];
    chain[0].hd = s_tdata[608 +: md5_pkg::WORD_W];
    chain[0].a  = chain[0].ha;
    chain[0].b  = chain[0].hb;
    chain[0].c  = chain[0].hc;
    chain[0].d  = chain[0].hd;
  end

  assign s_tready = run;

  // The chain of step cells.
  for (genvar g = 0; g < md5_pkg::NUM_STEPS; g++) begin : g_step
    md5_cell #(
      .STEP (g)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .run  (run),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  // Final add and output staging.
  md5_out_skid u_out (
    .clk      (clk),
    .rst      (rst),
    .din      (chain[md5_pkg::NUM_STEPS]),
    .run      (run),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// File: rtl/md5_block_compress_checker.sv
// Port-level checker for the MD5 block compression, bound to the top level.
module md5_block_compress_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [md5_pkg::OUT_W-1:0]  m_tdata
);

  // No result appears in the cycle after reset.
  a_idle_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // The input side only stalls while a result is waiting at the output.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

  // The input side stalls only after the output was blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> $past(m_tvalid && !m_tready))
    else $error("input stalled without output back-pressure");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind md5_block_compress md5_block_compress_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: tb/md5_block_compress_tb.sv
// Self-checking testbench for the pipelined MD5 block compression stream block.
`timescale 1ns / 1ps

module md5_block_compress_tb;

  localparam int unsigned RANDOM_BLOCKS  = 600;
  localparam int unsigned QUIET_TAIL     = 80;
  localparam int unsigned DRAIN_CYCLES   = 150;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef logic [31:0] word_t;

  // Message block and chaining value, packed exactly as s_tdata carries them.
  typedef struct packed {
    word_t              hd;
    word_t              hc;
    word_t              hb;
    word_t              ha;
    logic [15:0][31:0]  msg;
  } block_t;

  // Updated chaining value, packed as m_tdata carries it.
  typedef struct packed {
    word_t d;
    word_t c;
    word_t b;
    word_t a;
  } digest_t;

  // Additive constant of each of the 64 steps.
  localparam word_t ADD_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts per round, indexed by the step number modulo four.
  localparam int unsigned ROT_BY [4][4] = '{
    '{7, 12, 17, 22},
    '{5,  9, 14, 20},
    '{4, 11, 16, 23},
    '{6, 10, 15, 21}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [md5_pkg::IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [md5_pkg::OUT_W-1:0] m_tdata;

  block_t  pending_blocks[$];
  digest_t expected_digests[$];

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned src_chance = 0;
  int unsigned sink_chance = 0;

  md5_block_compress u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // Runs the 64 steps over one block and adds the incoming chaining value.
  function automatic digest_t md5_compress(block_t blk);
    word_t       a, b, c, d, f, sum, nb;
    int unsigned k, s;
    digest_t     res;
    a = blk.ha;
    b = blk.hb;
    c = blk.hc;
    d = blk.hd;
    for (int unsigned i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          k = i % 16;
        end
        1: begin
          f = (b & d) | (c & ~d);
          k = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          k = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          k = (7 * i) % 16;
        end
      endcase
      sum = a + f + ADD_K[i] + blk.msg[k];
      s = ROT_BY[i / 16][i % 4];
      nb = b + ((sum << s) | (sum >> (32 - s)));
      a = d;
      d = c;
      c = b;
      b = nb;
    end
    res.a = blk.ha + a;
    res.b = blk.hb + b;
    res.c = blk.hc + c;
    res.d = blk.hd + d;
    return res;
  endfunction

  // Random word biased toward the extremes and single-bit patterns.
  function automatic word_t rand_word();
    word_t w;
    case ($urandom_range(0, 7))
      0: w = '0;
      1: w = '1;
      2: w = word_t'(1) << $urandom_range(0, 31);
      3: w = ~(word_t'(1) << $urandom_range(0, 31));
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic block_t make_block(word_t mw, word_t ca, word_t cb, word_t cc, word_t cd);
    block_t blk;
    for (int i = 0; i < 16; i++) blk.msg[i] = mw;
    blk.ha = ca;
    blk.hb = cb;
    blk.hc = cc;
    blk.hd = cd;
    return blk;
  endfunction

  // Idle rates change now and then; zero gives stretches with no idling at all.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 256 == 0) begin
      src_chance <= $urandom_range(0, 3);
      sink_chance <= $urandom_range(0, 3);
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("md5_block_compress_tb NOT OK");
      $finish;
    end
  end

  // Source side: the prediction is made when a transfer completes.
  always @(posedge clk) begin : source_proc
    logic   send;
    block_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_digests.push_back(md5_compress(block_t'(s_tdata)));
      end
      if (!s_tvalid || s_tready) begin
        send = 1'b0;
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_blocks.size() > QUIET_TAIL && src_chance != 0 &&
                     $urandom_range(0, 7) < src_chance) begin
          src_gap = $urandom_range(0, 14);
        end else if (pending_blocks.size() > 0) begin
          nxt = pending_blocks.pop_front();
          send = 1'b1;
          s_tdata <= nxt;
        end
        s_tvalid <= send;
      end
    end
  end

  // Sink side: stall at random and check every result transfer in order.
  always @(posedge clk) begin : sink_proc
    digest_t got;
    digest_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = digest_t'(m_tdata);
        if (expected_digests.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result: a=%h b=%h c=%h d=%h", got.a, got.b, got.c, got.d);
        end else begin
          want = expected_digests.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("mismatch: expected a=%h b=%h c=%h d=%h, got a=%h b=%h c=%h d=%h",
                       want.a, want.b, want.c, want.d, got.a, got.b, got.c, got.d);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else if (pending_blocks.size() > QUIET_TAIL && sink_chance != 0 &&
                   $urandom_range(0, 7) < sink_chance) begin
        sink_gap = $urandom_range(0, 14);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stim_proc
    block_t blk;
    // Directed blocks: extremes, alternating patterns and the padded empty message.
    pending_blocks.push_back(make_block('0, '0, '0, '0, '0));
    pending_blocks.push_back(make_block('1, '1, '1, '1, '1));
    pending_blocks.push_back(make_block('1, '0, '0, '0, '0));
    pending_blocks.push_back(make_block('0, '1, '1, '1, '1));
    pending_blocks.push_back(make_block(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa,
                                        32'haaaaaaaa, 32'haaaaaaaa));
    pending_blocks.push_back(make_block(32'haaaaaaaa, 32'h55555555, 32'h55555555,
                                        32'h55555555, 32'h55555555));
    blk = make_block('0, 32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476);
    blk.msg[0] = 32'h00000080;
    pending_blocks.push_back(blk);
    // A single top bit walked through each message word, from the standard start value.
    for (int i = 0; i < 16; i++) begin
      blk = make_block('0, 32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476);
      blk.msg[i] = 32'h80000000;
      pending_blocks.push_back(blk);
    end
    // Random blocks.
    for (int n = 0; n < RANDOM_BLOCKS; n++) begin
      for (int i = 0; i < 16; i++) blk.msg[i] = rand_word();
      blk.ha = rand_word();
      blk.hb = rand_word();
      blk.hc = rand_word();
      blk.hd = rand_word();
      pending_blocks.push_back(blk);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Wait until every block has been taken and every result has come back.
    do begin
      @(negedge clk);
    end while (pending_blocks.size() != 0 || s_tvalid || expected_digests.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("md5_block_compress_tb OK");
    end else begin
      $display("md5_block_compress_tb NOT OK");
    end
    $finish;
  end

endmodule
